>>> rtl/core/gimd_pkg.sv
// Package for the grouped interrupt mask and dispatch block.
// Holds the item, enable and result types, command codes, group masks and
// the bit mapping functions. Depends on nothing.
package gimd_pkg;

	// Command codes carried by an input beat.
	localparam logic [1:0] CMD_DISPATCH = 2'd0;
	localparam logic [1:0] CMD_MASK     = 2'd1;
	localparam logic [1:0] CMD_UNMASK   = 2'd2;

	// Dispatch status codes.
	localparam logic [1:0] STAT_NONE       = 2'd0;
	localparam logic [1:0] STAT_TAKEN      = 2'd1;
	localparam logic [1:0] STAT_NO_HANDLER = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MASK      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_PRESENT = 1'd1;

	// Interrupt bits owned by each source group; bit 31 is interrupt 0.
	localparam logic [31:0] GRP_MEM  = 32'hF800_0000;
	localparam logic [31:0] GRP_DSP  = 32'h0700_0000;
	localparam logic [31:0] GRP_AUD  = 32'h0080_0000;
	localparam logic [31:0] GRP_SER0 = 32'h0070_0000;
	localparam logic [31:0] GRP_SER1 = 32'h000E_0000;
	localparam logic [31:0] GRP_SER2 = 32'h0001_8000;
	localparam logic [31:0] GRP_MAIN = 32'h0000_7FE0;

	// Reset values of the mask and the processor-interface enable word.
	localparam logic [31:0] GLOBAL_MASK_RST = 32'hFFFF_FFE0;
	localparam logic [13:0] MAIN_EN_FIXED   = 14'h00F0;

	// Fixed priority rows, searched from the first row down.
	localparam int PRIO_ROWS_N = 11;
	localparam logic [31:0] PRIO_ROWS [PRIO_ROWS_N] = '{
		32'h0000_0100, 32'h0000_0040, 32'hF800_0000, 32'h0000_0200,
		32'h0000_0080, 32'h0000_3000, 32'h0000_0020, 32'h03FF_8C00,
		32'h0400_0000, 32'h0000_4000, 32'hFFFF_FFFF
	};

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] mask_bits;
		logic [15:0] main_cause;
		logic [4:0]  mem_pending;
		logic [2:0]  dsp_pending;
		logic        audio_pending;
		logic [2:0]  serial0_pending;
		logic [2:0]  serial1_pending;
		logic [1:0]  serial2_pending;
	} item_t;

	typedef struct packed {
		logic [4:0]  mem;
		logic [2:0]  dsp;
		logic        audio;
		logic [2:0]  serial0;
		logic [2:0]  serial1;
		logic [1:0]  serial2;
		logic [13:0] main;
	} enables_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  number;
		logic [31:0] prev_mask;
		logic [6:0]  written;
		enables_t    en;
	} result_t;

	// Enable values of every group for a given set of unmasked interrupts.
	function automatic enables_t enables_from_ok(input logic [31:0] ok);
		enables_t e;
		e.mem     = {ok[27], ok[28], ok[29], ok[30], ok[31]};
		e.dsp     = {ok[24], ok[25], ok[26]};
		e.audio   = ok[23];
		e.serial0 = {ok[20], ok[21], ok[22]};
		e.serial1 = {ok[17], ok[18], ok[19]};
		e.serial2 = {ok[15], ok[16]};
		e.main    = MAIN_EN_FIXED;
		e.main[13] = ok[5];
		e.main[12] = ok[6];
		e.main[11] = ok[14];
		e.main[10] = ok[12];
		e.main[9]  = ok[13];
		e.main[8]  = ok[7];
		e.main[3]  = ok[11];
		e.main[2]  = ok[10];
		e.main[1]  = ok[9];
		e.main[0]  = ok[8];
		return e;
	endfunction

	// Leading-zero count of a nonzero word: pick the top busy byte, then the
	// top bit inside it.
	function automatic logic [4:0] lead_zeros(input logic [31:0] v);
		logic [1:0] top;
		logic [2:0] pos;
		logic [7:0] byte_v;
		top = 2'd0;
		pos = 3'd0;
		for (int b = 0; b < 4; b++) begin
			if (v[b*8 +: 8] != 8'd0) begin
				top = 2'(b);
			end
		end
		byte_v = v[top*8 +: 8];
		for (int k = 0; k < 8; k++) begin
			if (byte_v[k]) begin
				pos = 3'(k);
			end
		end
		return 5'd31 - {top, pos};
	endfunction

endpackage

>>> rtl/core/gimd_if.sv
// Channel interfaces of the grouped interrupt mask and dispatch block.
// Input item, result and configuration write channels, each valid/ready.
// Depends on nothing.

interface gimd_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] mask_bits;
	logic [15:0] main_cause;
	logic [4:0]  mem_pending;
	logic [2:0]  dsp_pending;
	logic        audio_pending;
	logic [2:0]  serial0_pending;
	logic [2:0]  serial1_pending;
	logic [1:0]  serial2_pending;

	modport source (
		output valid, cmd, mask_bits, main_cause, mem_pending, dsp_pending,
		       audio_pending, serial0_pending, serial1_pending, serial2_pending,
		input  ready
	);
	modport sink (
		input  valid, cmd, mask_bits, main_cause, mem_pending, dsp_pending,
		       audio_pending, serial0_pending, serial1_pending, serial2_pending,
		output ready
	);
endinterface

interface gimd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  dispatch_status;
	logic [4:0]  interrupt_number;
	logic [31:0] previous_mask;
	logic [6:0]  groups_written;
	logic [4:0]  mem_enable;
	logic [2:0]  dsp_enable;
	logic        audio_enable;
	logic [2:0]  serial0_enable;
	logic [2:0]  serial1_enable;
	logic [1:0]  serial2_enable;
	logic [13:0] main_enable;

	modport source (
		output valid, dispatch_status, interrupt_number, previous_mask,
		       groups_written, mem_enable, dsp_enable, audio_enable,
		       serial0_enable, serial1_enable, serial2_enable, main_enable,
		input  ready
	);
	modport sink (
		input  valid, dispatch_status, interrupt_number, previous_mask,
		       groups_written, mem_enable, dsp_enable, audio_enable,
		       serial0_enable, serial1_enable, serial2_enable, main_enable,
		output ready
	);
endinterface

interface gimd_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/gimd_dispatch.sv
// Dispatch path: builds the cause word from raw pending bits, masks it and
// picks one interrupt by the fixed priority rows. Depends on gimd_pkg.
module gimd_dispatch (
	input  gimd_pkg::item_t   item,
	input  logic [13:0]       main_enable,
	input  logic [31:0]       mask_all,
	input  logic [31:0]       handler_present,
	output logic [1:0]        status,
	output logic [4:0]        number
);
	import gimd_pkg::*;

	logic [15:0] mc;
	logic        live;
	logic [31:0] cause;
	logic [31:0] unmasked;
	logic [31:0] sel;
	logic [4:0]  lz;

	assign mc   = item.main_cause;
	assign live = (mc[13:0] & main_enable) != 14'd0;

	// Map the gated group pending bits and the main cause bits into one word.
	always_comb begin
		cause = 32'd0;
		if (mc[7]) begin
			cause[31:27] = {item.mem_pending[0], item.mem_pending[1],
				item.mem_pending[2], item.mem_pending[3], item.mem_pending[4]};
		end
		if (mc[6]) begin
			cause[26:24] = {item.dsp_pending[0], item.dsp_pending[1],
				item.dsp_pending[2]};
		end
		if (mc[5]) begin
			cause[23] = item.audio_pending;
		end
		if (mc[4]) begin
			cause[22:20] = {item.serial0_pending[0], item.serial0_pending[1],
				item.serial0_pending[2]};
			cause[19:17] = {item.serial1_pending[0], item.serial1_pending[1],
				item.serial1_pending[2]};
			cause[16:15] = {item.serial2_pending[0], item.serial2_pending[1]};
		end
		cause[5]  = mc[13];
		cause[6]  = mc[12];
		cause[12] = mc[10];
		cause[13] = mc[9];
		cause[7]  = mc[8];
		cause[11] = mc[3];
		cause[10] = mc[2];
		cause[9]  = mc[1];
		cause[14] = mc[11];
		cause[8]  = mc[0];
	end

	assign unmasked = cause & ~mask_all;

	// Walk the rows from the last to the first so that the first hit wins.
	always_comb begin
		sel = 32'd0;
		for (int r = PRIO_ROWS_N - 1; r >= 0; r--) begin
			if ((unmasked & PRIO_ROWS[r]) != 32'd0) begin
				sel = unmasked & PRIO_ROWS[r];
			end
		end
	end

	assign lz = lead_zeros(sel);

	// Report the chosen number and whether a handler is registered for it.
	always_comb begin
		status = STAT_NONE;
		number = 5'd0;
		if (item.cmd == CMD_DISPATCH && live && unmasked != 32'd0) begin
			number = lz;
			status = handler_present[lz] ? STAT_TAKEN : STAT_NO_HANDLER;
		end
	end

endmodule

>>> rtl/core/grouped_interrupt_mask_and_dispatch.sv
// Grouped interrupt mask and dispatch, top level.
// Holds the global mask, the group enable registers and the configuration
// words. Depends on gimd_pkg, gimd_if and gimd_dispatch.
//
// Use: commands enter on the item channel and each produces exactly one beat
// on the result channel, in order. A mask command ORs mask_bits into the
// global mask, an unmask command clears them; both return the previous mask,
// rewrite the enable registers of every group with a changed bit and report
// those groups. A dispatch command returns the chosen interrupt number and
// whether a handler is present. Every result carries the enable registers
// as they stand after the command.
// The cfg channel writes local_mask (index 0) and handler_present (index 1);
// it is always ready. The user must write it only while the block is idle;
// the block does not enforce this. Each item beat passes one input register,
// then the mask, mapping and priority logic into the result register. One
// item is accepted every cycle while the receiver takes results. When the
// receiver stalls, the full result register holds and the input register
// takes one more beat; then item.ready drops until the result is taken.
// Reset sets the global mask to 0xFFFFFFE0, the main enable word to 0xF0,
// the other enables and both configuration words to zero, with both
// pipeline registers empty.
module grouped_interrupt_mask_and_dispatch (
	input  logic                 clk,
	input  logic                 arst_n,
	gimd_item_if.sink            item,
	gimd_result_if.source        result,
	gimd_cfg_if.sink             cfg
);
	import gimd_pkg::*;

	// Input stage and result register.
	item_t       item_s1;
	logic        valid_s1;
	result_t     res_q;
	logic        res_valid_q;
	logic        advance;

	// Block state.
	logic [31:0] global_mask_q;
	enables_t    en_q;
	logic [31:0] local_mask_q;
	logic [31:0] handler_present_q;

	// Next values computed from the input stage.
	logic [31:0] cur_mask;
	logic [31:0] changed;
	logic [31:0] global_mask_nx;
	logic [31:0] ok;
	enables_t    en_all;
	enables_t    en_nx;
	logic [6:0]  written;
	logic [31:0] prev_mask;
	logic [1:0]  disp_status;
	logic [4:0]  disp_number;
	logic        is_mask_cmd;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= '{cmd: item.cmd, mask_bits: item.mask_bits,
				main_cause: item.main_cause, mem_pending: item.mem_pending,
				dsp_pending: item.dsp_pending, audio_pending: item.audio_pending,
				serial0_pending: item.serial0_pending,
				serial1_pending: item.serial1_pending,
				serial2_pending: item.serial2_pending};
		end
	end

	// Mask and unmask: new mask, changed bits and group rewrites.
	assign is_mask_cmd = item_s1.cmd == CMD_MASK || item_s1.cmd == CMD_UNMASK;
	assign cur_mask    = global_mask_q | local_mask_q;

	always_comb begin
		case (item_s1.cmd)
			CMD_MASK: begin
				changed        = ~cur_mask & item_s1.mask_bits;
				global_mask_nx = global_mask_q | item_s1.mask_bits;
			end
			CMD_UNMASK: begin
				changed        = cur_mask & item_s1.mask_bits;
				global_mask_nx = global_mask_q & ~item_s1.mask_bits;
			end
			default: begin
				changed        = 32'd0;
				global_mask_nx = global_mask_q;
			end
		endcase
	end

	assign ok     = ~(global_mask_nx | local_mask_q);
	assign en_all = enables_from_ok(ok);

	always_comb begin
		en_nx      = en_q;
		written    = 7'd0;
		written[0] = (changed & GRP_MEM)  != 32'd0;
		written[1] = (changed & GRP_DSP)  != 32'd0;
		written[2] = (changed & GRP_AUD)  != 32'd0;
		written[3] = (changed & GRP_SER0) != 32'd0;
		written[4] = (changed & GRP_SER1) != 32'd0;
		written[5] = (changed & GRP_SER2) != 32'd0;
		written[6] = (changed & GRP_MAIN) != 32'd0;
		if (written[0]) begin
			en_nx.mem = en_all.mem;
		end
		if (written[1]) begin
			en_nx.dsp = en_all.dsp;
		end
		if (written[2]) begin
			en_nx.audio = en_all.audio;
		end
		if (written[3]) begin
			en_nx.serial0 = en_all.serial0;
		end
		if (written[4]) begin
			en_nx.serial1 = en_all.serial1;
		end
		if (written[5]) begin
			en_nx.serial2 = en_all.serial2;
		end
		if (written[6]) begin
			en_nx.main = en_all.main;
		end
	end

	assign prev_mask = is_mask_cmd ? global_mask_q : 32'd0;

	// Dispatch path on the current state.
	gimd_dispatch u_dispatch (
		.item            (item_s1),
		.main_enable     (en_q.main),
		.mask_all        (cur_mask),
		.handler_present (handler_present_q),
		.status          (disp_status),
		.number          (disp_number)
	);

	// Block state, updated as each item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_mask_q <= GLOBAL_MASK_RST;
			en_q          <= '{mem: 5'd0, dsp: 3'd0, audio: 1'b0, serial0: 3'd0,
				serial1: 3'd0, serial2: 2'd0, main: MAIN_EN_FIXED};
		end else if (advance) begin
			global_mask_q <= global_mask_nx;
			en_q          <= en_nx;
		end
	end

	// Configuration words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mask_q      <= 32'd0;
			handler_present_q <= 32'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LOCAL_MASK:      local_mask_q      <= cfg.data;
				CFG_HANDLER_PRESENT: handler_present_q <= cfg.data;
				default:             ;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= '{status: disp_status, number: disp_number,
				prev_mask: prev_mask, written: written, en: en_nx};
		end
	end

	assign result.valid            = res_valid_q;
	assign result.dispatch_status  = res_q.status;
	assign result.interrupt_number = res_q.number;
	assign result.previous_mask    = res_q.prev_mask;
	assign result.groups_written   = res_q.written;
	assign result.mem_enable       = res_q.en.mem;
	assign result.dsp_enable       = res_q.en.dsp;
	assign result.audio_enable     = res_q.en.audio;
	assign result.serial0_enable   = res_q.en.serial0;
	assign result.serial1_enable   = res_q.en.serial1;
	assign result.serial2_enable   = res_q.en.serial2;
	assign result.main_enable      = res_q.en.main;

endmodule
